FILE: hdl/srfr_pkg.sv
// shared constants, codes and command/status types of the servo reply frame receiver
package srfr_pkg;

    localparam int MAX_FRAME_BYTES = 32;
    localparam int PARAM_DEPTH     = MAX_FRAME_BYTES - 6;
    localparam int IDX_W           = 5;
    localparam int LEN_W           = 6;
    localparam int ST_W            = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] MIN_LEN  = 8'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FRAME_ERR = 2'd1;
    localparam logic [ST_W-1:0] ST_CHK_ERR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

    typedef enum logic [1:0] {
        EMIT_FRAME_ERR,
        EMIT_CHK_ERR,
        EMIT_EMPTY,
        EMIT_PARAM
    } emit_kind_t;

    typedef struct packed {
        logic       cap_id;
        logic       cap_len;
        logic       cap_cmd;
        logic       cap_param;
        logic       emit;
        emit_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic hdr_byte;
        logic len_bad;
        logic n_zero;
        logic last_param;
        logic id_cmd_bad;
        logic chk_bad;
        logic replay_last;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: hdl/srfr_ctrl.sv
// frame sequencing state machine of the servo reply frame receiver
module srfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  srfr_pkg::dp_stat_t stat,
    output srfr_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_HUNT   = 3'd0;
    localparam logic [2:0] S_ID     = 3'd1;
    localparam logic [2:0] S_LEN    = 3'd2;
    localparam logic [2:0] S_CMD    = 3'd3;
    localparam logic [2:0] S_PARAM  = 3'd4;
    localparam logic [2:0] S_CHK    = 3'd5;
    localparam logic [2:0] S_REPLAY = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       prev_hdr_reg, prev_hdr_next;
    logic       take;

    assign rx_stall = (state_reg == S_REPLAY) || !stat.out_free;
    assign take     = rx_valid && !rx_stall;

    always_comb
    begin
        state_next    = state_reg;
        prev_hdr_next = prev_hdr_reg;
        cmd           = '0;
        cmd.kind      = srfr_pkg::EMIT_FRAME_ERR;
        unique case (state_reg)
            S_HUNT:
            begin
                if (take)
                begin
                    if (prev_hdr_reg && stat.hdr_byte)
                    begin
                        prev_hdr_next = 1'b0;
                        state_next    = S_ID;
                    end
                    else
                    begin
                        prev_hdr_next = stat.hdr_byte;
                    end
                end
            end
            S_ID:
            begin
                if (take)
                begin
                    cmd.cap_id = 1'b1;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (take)
                begin
                    cmd.cap_len = 1'b1;
                    if (stat.len_bad)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = srfr_pkg::EMIT_FRAME_ERR;
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        state_next = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                if (take)
                begin
                    cmd.cap_cmd = 1'b1;
                    state_next  = stat.n_zero ? S_CHK : S_PARAM;
                end
            end
            S_PARAM:
            begin
                if (take)
                begin
                    cmd.cap_param = 1'b1;
                    if (stat.last_param)
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (take)
                begin
                    priority if (stat.id_cmd_bad)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = srfr_pkg::EMIT_FRAME_ERR;
                        state_next = S_HUNT;
                    end
                    else if (stat.chk_bad)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = srfr_pkg::EMIT_CHK_ERR;
                        state_next = S_HUNT;
                    end
                    else if (stat.n_zero)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = srfr_pkg::EMIT_EMPTY;
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        state_next = S_REPLAY;
                    end
                end
            end
            S_REPLAY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = srfr_pkg::EMIT_PARAM;
                    if (stat.replay_last)
                    begin
                        state_next = S_HUNT;
                    end
                end
            end
            default:
            begin
                state_next    = S_HUNT;
                prev_hdr_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_HUNT;
            prev_hdr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_hdr_reg <= prev_hdr_next;
        end
    end

endmodule

FILE: hdl/srfr_datapath.sv
// frame fields, checksum, parameter store and result register
module srfr_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [7:0]                         rx_byte,
    input  logic                               cfg_valid,
    input  logic [srfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data,
    input  srfr_pkg::dp_cmd_t                  cmd,
    output srfr_pkg::dp_stat_t                 stat,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [srfr_pkg::ST_W-1:0]          status,
    output logic [7:0]                         param_byte,
    output logic [srfr_pkg::IDX_W-1:0]         param_index,
    output logic [srfr_pkg::IDX_W-1:0]         param_count,
    output logic [srfr_pkg::LEN_W-1:0]         frame_length,
    output logic                               last
);

    logic [7:0]                     exp_id_reg;
    logic [7:0]                     exp_cmd_reg;
    logic [srfr_pkg::LEN_W-1:0]     max_len_reg;

    logic [7:0]                     id_reg;
    logic [7:0]                     cmd_reg;
    logic [7:0]                     sum_reg;
    logic [srfr_pkg::IDX_W-1:0]     n_reg;
    logic [srfr_pkg::IDX_W-1:0]     cnt_reg;
    logic [srfr_pkg::IDX_W-1:0]     rp_reg;
    logic [7:0]                     store [srfr_pkg::PARAM_DEPTH];

    logic                           out_valid_reg;
    logic [srfr_pkg::ST_W-1:0]      out_st_reg;
    logic [7:0]                     out_pb_reg;
    logic [srfr_pkg::IDX_W-1:0]     out_pi_reg;
    logic [srfr_pkg::IDX_W-1:0]     out_pc_reg;
    logic [srfr_pkg::LEN_W-1:0]     out_fl_reg;
    logic                           out_last_reg;

    logic [srfr_pkg::LEN_W-1:0]     lim;
    logic [8:0]                     total_in;
    logic [srfr_pkg::LEN_W-1:0]     frame_total;

    // frame length limit is the smaller of the register and the maximum frame size
    assign lim = (max_len_reg > srfr_pkg::LEN_W'(srfr_pkg::MAX_FRAME_BYTES))
               ? srfr_pkg::LEN_W'(srfr_pkg::MAX_FRAME_BYTES) : max_len_reg;
    assign total_in    = {1'b0, rx_byte} + 9'(srfr_pkg::MIN_LEN);
    assign frame_total = {1'b0, n_reg} + srfr_pkg::LEN_W'(6);

    assign stat.hdr_byte    = (rx_byte == srfr_pkg::HDR_BYTE);
    assign stat.len_bad     = (rx_byte < srfr_pkg::MIN_LEN) || (total_in > {3'b0, lim});
    assign stat.n_zero      = (n_reg == '0);
    assign stat.last_param  = ({1'b0, cnt_reg} + 6'd1) >= {1'b0, n_reg};
    assign stat.id_cmd_bad  = (id_reg != exp_id_reg) || (cmd_reg != exp_cmd_reg);
    assign stat.chk_bad     = (rx_byte != ~sum_reg);
    assign stat.replay_last = ({1'b0, rp_reg} + 6'd1) == {1'b0, n_reg};
    assign stat.out_free    = !out_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg  <= 8'd0;
            exp_cmd_reg <= 8'd0;
            max_len_reg <= srfr_pkg::LEN_W'(srfr_pkg::MAX_FRAME_BYTES);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                srfr_pkg::CFG_EXP_ID:  exp_id_reg  <= cfg_data;
                srfr_pkg::CFG_EXP_CMD: exp_cmd_reg <= cfg_data;
                srfr_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data[srfr_pkg::LEN_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= 8'd0;
            cmd_reg <= 8'd0;
            sum_reg <= 8'd0;
            n_reg   <= '0;
            cnt_reg <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            if (cmd.cap_id)
            begin
                id_reg  <= rx_byte;
                sum_reg <= rx_byte;
            end
            if (cmd.cap_len)
            begin
                sum_reg <= sum_reg + rx_byte;
                n_reg   <= rx_byte[srfr_pkg::IDX_W-1:0] - srfr_pkg::IDX_W'(srfr_pkg::MIN_LEN);
            end
            if (cmd.cap_cmd)
            begin
                cmd_reg <= rx_byte;
                sum_reg <= sum_reg + rx_byte;
                cnt_reg <= '0;
                rp_reg  <= '0;
            end
            if (cmd.cap_param)
            begin
                sum_reg <= sum_reg + rx_byte;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.emit && cmd.kind == srfr_pkg::EMIT_PARAM)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_param)
        begin
            store[cnt_reg] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            unique case (cmd.kind)
                srfr_pkg::EMIT_FRAME_ERR,
                srfr_pkg::EMIT_CHK_ERR:
                begin
                    out_st_reg   <= (cmd.kind == srfr_pkg::EMIT_CHK_ERR)
                                  ? srfr_pkg::ST_CHK_ERR : srfr_pkg::ST_FRAME_ERR;
                    out_pb_reg   <= 8'd0;
                    out_pi_reg   <= '0;
                    out_pc_reg   <= '0;
                    out_fl_reg   <= '0;
                    out_last_reg <= 1'b1;
                end
                srfr_pkg::EMIT_EMPTY:
                begin
                    out_st_reg   <= srfr_pkg::ST_OK;
                    out_pb_reg   <= 8'd0;
                    out_pi_reg   <= '0;
                    out_pc_reg   <= '0;
                    out_fl_reg   <= frame_total;
                    out_last_reg <= 1'b1;
                end
                srfr_pkg::EMIT_PARAM:
                begin
                    out_st_reg   <= srfr_pkg::ST_OK;
                    out_pb_reg   <= store[rp_reg];
                    out_pi_reg   <= rp_reg;
                    out_pc_reg   <= n_reg;
                    out_fl_reg   <= frame_total;
                    out_last_reg <= stat.replay_last;
                end
                default:
                begin
                    out_st_reg <= srfr_pkg::ST_FRAME_ERR;
                end
            endcase
        end
    end

    assign res_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign param_byte   = out_pb_reg;
    assign param_index  = out_pi_reg;
    assign param_count  = out_pc_reg;
    assign frame_length = out_fl_reg;
    assign last         = out_last_reg;

endmodule

FILE: hdl/servo_reply_frame_receiver_core.sv
// top level: servo reply frame receiver, state machine plus datapath
// an error beat leaves in the cycle after the length or checksum byte that shows the error is taken
// throughput: one received byte per cycle when not stalled; after the checksum byte the n parameter
//   beats follow at one a cycle while the result register is not held
// while parameters replay no byte is taken; a result held by the receiver blocks every byte
// reset: rst_n clears state, config to defaults; the parameter store is not cleared
module servo_reply_frame_receiver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rx_valid,
    output logic                           rx_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [srfr_pkg::ST_W-1:0]      status,
    output logic [7:0]                     param_byte,
    output logic [srfr_pkg::IDX_W-1:0]     param_index,
    output logic [srfr_pkg::IDX_W-1:0]     param_count,
    output logic [srfr_pkg::LEN_W-1:0]     frame_length,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    srfr_pkg::dp_cmd_t  cmd;
    srfr_pkg::dp_stat_t stat;

    // each register write is taken as soon as cfg_valid is high, so the port never pushes back
    assign cfg_ready = 1'b1;

    // sequencing: header hunt, field capture, checks and parameter replay
    srfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // frame fields, running sum, parameter store and the result register
    srfr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .status       (status),
        .param_byte   (param_byte),
        .param_index  (param_index),
        .param_count  (param_count),
        .frame_length (frame_length),
        .last         (last)
    );

`ifndef SYNTHESIS
    // an error beat carries nothing but its status and ends the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != srfr_pkg::ST_OK |-> last && frame_length == '0)
        else $error("error beat with payload or without last marker");

    // the last parameter beat sits at the final parameter index
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last && param_count != '0 |-> param_index + 1'b1 == param_count)
        else $error("last marker on wrong parameter index");

    // a taken beat inside a replay is followed straight away by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !last |=> res_valid)
        else $error("gap inside parameter replay");
`endif

endmodule
